@@ src/l2vn_pkg.sv @@
package l2vn_pkg;

    // Element and result widths are fixed by the data format
    localparam int ELEM_W  = 16;
    localparam int SUM_W   = 37;
    // Norm holds floor(sqrt(sum * 2^16)): 54-bit radicand (one leading zero
    // keeps the bit pairs aligned to the LSB), 27-bit root
    localparam int RAD_W   = SUM_W + 17;
    localparam int ROOT_W  = RAD_W / 2;
    // Dividend is |e| * 2^24 + norm, divisor is 2 * norm
    localparam int DVD_W   = 42;
    localparam int DIV_W   = ROOT_W + 1;
    localparam int Q_W     = DVD_W - 1;
    localparam logic [ELEM_W-1:0] SAT_MAX = 16'h7FFF;

    // Commands from controller to datapath
    typedef struct packed {
        logic store;      // write element, add square
        logic drop;       // element beyond capacity
        logic sqrt_start; // load radicand into root unit
        logic sqrt_step;  // one root iteration
        logic rd_start;   // read store entry at r_rd_idx
        logic div_start;  // load quotient unit
        logic div_step;   // one quotient iteration
        logic clear;      // clear vector state
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [6:0] count;
        logic       rd_last;
    } t_sts;

endpackage

@@ src/l2vn_if.sv @@
interface l2vn_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] element_value;
    logic        last_element;
    modport source (output valid, element_value, last_element, input ready);
    modport sink   (input valid, element_value, last_element, output ready);
endinterface

interface l2vn_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] normalized_value;
    logic        last_result;
    logic        zero_norm;
    logic        length_overflow;
    modport source (output valid, normalized_value, last_result, zero_norm,
                    length_overflow, input ready);
    modport sink   (input valid, normalized_value, last_result, zero_norm,
                    length_overflow, output ready);
endinterface

@@ src/l2vn_datapath.sv @@
module l2vn_datapath import l2vn_pkg::*; #(
    parameter int MAX_LEN = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [ELEM_W-1:0] i_elem,
    output t_sts              o_sts,
    output logic [ELEM_W-1:0] o_value,
    output logic              o_zero,
    output logic              o_ovf
);
    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [ELEM_W-1:0] mem [MAX_LEN];
    logic [ELEM_W-1:0] r_rd_data;
    logic [SUM_W-1:0]  r_sum;
    logic [6:0]        r_count;
    logic [6:0]        r_rd_idx;
    logic              r_ovf;
    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W:0]   r_rem;
    logic [DVD_W-1:0]  r_dvd;
    logic [Q_W-1:0]    r_quo;
    logic [DVD_W:0]    r_prem;
    logic              r_neg;

    logic [ELEM_W-1:0] mag_in;
    logic [31:0]       sq_in;
    logic [SUM_W-1:0]  sum_add;
    logic [SUM_W-1:0]  rad_sum;
    logic [ROOT_W+1:0] trial;
    logic [ROOT_W+1:0] rem_sh;
    logic [DVD_W:0]    prem_sh;
    logic [DIV_W-1:0]  divisor;
    logic [ELEM_W-1:0] mag_rd;
    logic [ELEM_W-1:0] q_sat;

    // Element magnitude and square
    assign mag_in = i_elem[ELEM_W-1] ? (~i_elem + 1'b1) : i_elem;
    assign sq_in  = mag_in * mag_in;

    // Running sum; the root takes the sum including an element stored this cycle
    assign sum_add = r_sum + SUM_W'(sq_in);
    assign rad_sum = i_cmd.store ? sum_add : r_sum;

    // Restoring square root: two radicand bits per step
    assign rem_sh = {r_rem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};

    // Restoring divide: one quotient bit per step
    assign divisor = {r_root, 1'b0};
    assign prem_sh = {r_prem[DVD_W-1:0], r_dvd[DVD_W-1]};
    assign mag_rd  = r_rd_data[ELEM_W-1] ? (~r_rd_data + 1'b1) : r_rd_data;
    assign q_sat   = (r_quo > Q_W'(SAT_MAX)) ? SAT_MAX : r_quo[ELEM_W-1:0];

    // Element store
    always_ff @(posedge i_clk) begin
        if (i_cmd.store)
            mem[r_count[IDX_W-1:0]] <= i_elem;
        if (i_cmd.rd_start)
            r_rd_data <= mem[r_rd_idx[IDX_W-1:0]];
    end

    // Vector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_rd_idx <= '0;
        end else if (i_cmd.clear) begin
            r_sum    <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_rd_idx <= '0;
        end else begin
            if (i_cmd.store) begin
                r_sum   <= sum_add;
                r_count <= r_count + 7'd1;
            end
            if (i_cmd.drop)
                r_ovf <= 1'b1;
            if (i_cmd.rd_start)
                r_rd_idx <= r_rd_idx + 7'd1;
        end
    end

    // Root and quotient units
    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_rad  <= {1'b0, rad_sum, 16'd0};
            r_root <= '0;
            r_rem  <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= (ROOT_W+1)'(rem_sh - trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[ROOT_W:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.div_start) begin
            r_dvd  <= {2'b00, mag_rd, 24'd0} + DVD_W'(r_root);
            r_quo  <= '0;
            r_prem <= '0;
            r_neg  <= r_rd_data[ELEM_W-1];
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            if (prem_sh >= (DVD_W+1)'(divisor)) begin
                r_prem <= prem_sh - (DVD_W+1)'(divisor);
                r_quo  <= {r_quo[Q_W-2:0], 1'b1};
            end else begin
                r_prem <= prem_sh;
                r_quo  <= {r_quo[Q_W-2:0], 1'b0};
            end
        end
    end

    assign o_zero         = (r_root == '0);
    assign o_ovf          = r_ovf;
    assign o_value        = o_zero ? r_rd_data : (r_neg ? (~q_sat + 1'b1) : q_sat);
    assign o_sts.count    = r_count;
    assign o_sts.rd_last  = (r_rd_idx == r_count);
endmodule

@@ src/l2vn_ctrl.sv @@
module l2vn_ctrl import l2vn_pkg::*; #(
    parameter int MAX_LEN = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_last,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    output logic o_out_last,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [2:0] {
        S_LOAD, S_SQRT, S_READ, S_LDDIV, S_DIV, S_OUT, S_CLEAR
    } t_state;

    t_state     r_state;
    logic [5:0] r_cnt;
    logic       r_last;
    logic       in_xfer;
    logic       room;

    assign in_xfer    = i_in_valid && (r_state == S_LOAD);
    assign o_in_ready = (r_state == S_LOAD);
    assign room       = (i_sts.count < 7'(MAX_LEN));

    always_comb begin
        o_cmd            = '0;
        o_cmd.store      = in_xfer && room;
        o_cmd.drop       = in_xfer && !room;
        o_cmd.sqrt_start = in_xfer && i_in_last;
        o_cmd.sqrt_step  = (r_state == S_SQRT);
        o_cmd.rd_start   = (r_state == S_READ) && !i_sts.rd_last;
        o_cmd.div_start  = (r_state == S_LDDIV);
        o_cmd.div_step   = (r_state == S_DIV);
        o_cmd.clear      = (r_state == S_CLEAR) ||
                           ((r_state == S_READ) && i_sts.rd_last);
    end

    // Sequencer: load, root, then read/divide/emit per element
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_last      <= 1'b0;
            o_out_valid <= 1'b0;
            o_out_last  <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: if (in_xfer && i_in_last) begin
                    r_state <= S_SQRT;
                    r_cnt   <= 6'(ROOT_W - 1);
                end
                S_SQRT: begin
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == '0) r_state <= S_READ;
                end
                S_READ: begin
                    if (i_sts.rd_last) r_state <= S_LOAD;
                    else r_state <= S_LDDIV;
                end
                S_LDDIV: begin
                    r_state <= S_DIV;
                    r_cnt   <= 6'(DVD_W - 1);
                    r_last  <= i_sts.rd_last;
                end
                S_DIV: begin
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_state     <= S_OUT;
                        o_out_valid <= 1'b1;
                        o_out_last  <= r_last;
                    end
                end
                S_OUT: if (i_out_ready) begin
                    o_out_valid <= 1'b0;
                    r_state     <= r_last ? S_CLEAR : S_READ;
                end
                S_CLEAR: r_state <= S_LOAD;
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule

@@ src/l2_vector_normalize_unit.sv @@
// L2 vector normalize unit.
// Input channel (l2vn_in_if): one signed element per transfer; last_element
// closes the vector. Up to MAX_LEN elements are stored; further ones are
// dropped and length_overflow is set on every result of that vector.
// Output channel (l2vn_out_if): one result per stored element, in arrival
// order, as element / L2 norm in Q1.15, saturated to +/-32767. If the norm
// is zero, raw elements come out with zero_norm set.
// Timing: an element is taken on every transfer. After the last element the
// root unit runs one root bit per cycle, then each result takes a read, a load
// and the quotient steps (one quotient bit per cycle), plus an output state
// that holds until its transfer, and a clear state closes the vector.
// Input is held off while results drain.
// A stalled receiver holds the current result in the output register;
// the sequencer waits. Synchronous active-low reset returns to loading an
// empty vector; the element store itself is not cleared.
module l2_vector_normalize_unit import l2vn_pkg::*; #(
    parameter int MAX_LEN    = 64,
    parameter int ELEM_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    l2vn_in_if.sink    i_in,
    l2vn_out_if.source o_out
);
    t_cmd              cmd;
    t_sts              sts;
    logic [ELEM_W-1:0] elem;

    // Sign-extend input from ELEM_WIDTH bits
    assign elem = ELEM_W'($signed(i_in.element_value[ELEM_WIDTH-1:0]));

    l2vn_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last_element),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_last  (o_out.last_result),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    l2vn_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_elem  (elem),
        .o_sts   (sts),
        .o_value (o_out.normalized_value),
        .o_zero  (o_out.zero_norm),
        .o_ovf   (o_out.length_overflow)
    );
endmodule

@@ src/l2vn_checker.sv @@
module l2vn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_value,
    input logic        out_zero
);
    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value))
        else $error("result changed while stalled");
    // No input accepted while a result is pending
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready)
        else $error("input ready during drain");
    // Nonzero norm never yields -32768
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_zero |-> out_value != 16'h8000)
        else $error("unsaturated result");
    // Output idle right after reset
    a_rst: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !out_valid)
        else $error("valid after reset");
endmodule

bind l2_vector_normalize_unit l2vn_checker u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_value (o_out.normalized_value),
    .out_zero  (o_out.zero_norm)
);

@@ sim/l2vn_norm_checker.sv @@
`timescale 1ns / 1ps

module l2vn_norm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    l2vn_in_if.sink     i_in,
    l2vn_out_if.sink    i_out,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [15:0] value;
        logic        last;
        logic        zero;
        logic        ovf;
    } t_norm_result;

    localparam int MAX_LEN = 64;

    logic [15:0]  vec_elems [MAX_LEN];
    logic [36:0]  sq_sum;
    int           elem_cnt;
    logic         dropped;
    t_norm_result expected_results [$];

    assign o_pending = expected_results.size();

    // floor(sqrt(x)), bit by bit
    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Absorb one element; on last, queue the normalized vector
    task automatic absorb_element(input logic [15:0] elem, input logic last);
        logic [63:0]  mag;
        logic [63:0]  norm;
        logic [63:0]  quo;
        t_norm_result r;
        if (elem_cnt < MAX_LEN) begin
            mag = elem[15] ? 64'(17'h10000 - elem) : 64'(elem);
            vec_elems[elem_cnt] = elem;
            sq_sum = 37'(sq_sum + mag * mag);
            elem_cnt++;
        end else begin
            dropped = 1'b1;
        end
        if (!last) return;
        norm = isqrt(64'(sq_sum) << 16);
        for (int k = 0; k < elem_cnt; k++) begin
            if (norm == 0) begin
                r.value = vec_elems[k];
            end else begin
                mag = vec_elems[k][15] ? 64'(17'h10000 - vec_elems[k]) : 64'(vec_elems[k]);
                quo = ((mag << 24) + norm) / (norm << 1);
                if (quo > 32767) quo = 32767;
                r.value = vec_elems[k][15] ? 16'(17'h10000 - quo) : 16'(quo);
            end
            r.last = (k + 1 == elem_cnt);
            r.zero = (norm == 0);
            r.ovf  = dropped;
            expected_results.push_back(r);
        end
        sq_sum   = '0;
        elem_cnt = 0;
        dropped  = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_norm_result exp_r;
        int           errs;
        errs = 0;
        if (!i_rst_n) begin
            sq_sum       = '0;
            elem_cnt     = 0;
            dropped      = 1'b0;
            o_fail_count <= 0;
            expected_results.delete();
        end else begin
            // check output transfer first (results follow the last element)
            if (i_out.valid && i_out.ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result %h", i_out.normalized_value);
                    errs++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.value !== i_out.normalized_value) begin
                        $error("normalized_value exp %h got %h", exp_r.value,
                               i_out.normalized_value);
                        errs++;
                    end
                    if (exp_r.last !== i_out.last_result) begin
                        $error("last_result exp %b got %b", exp_r.last, i_out.last_result);
                        errs++;
                    end
                    if (exp_r.zero !== i_out.zero_norm) begin
                        $error("zero_norm exp %b got %b", exp_r.zero, i_out.zero_norm);
                        errs++;
                    end
                    if (exp_r.ovf !== i_out.length_overflow) begin
                        $error("length_overflow exp %b got %b", exp_r.ovf,
                               i_out.length_overflow);
                        errs++;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                absorb_element(i_in.element_value, i_in.last_element);
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

@@ sim/tb_l2_vector_normalize_unit.sv @@
`timescale 1ns / 1ps

module tb_l2_vector_normalize_unit;

    localparam int STALL_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   idle_cycles;
    int   sent;

    l2vn_in_if  in_ch ();
    l2vn_out_if out_ch ();

    l2_vector_normalize_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    l2vn_norm_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch.sink),
        .i_out        (out_ch.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver backpressure
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Drive one element and wait for its transfer; called at a falling edge
    task automatic send_element(input logic [15:0] elem, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.element_value <= elem;
        in_ch.last_element  <= last;
        while (!in_ch.ready) @(negedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic send_vector(input int len, input int kind);
        logic [15:0] elem;
        for (int k = 0; k < len; k++) begin
            case (kind)
                0: elem = 16'($urandom);
                1: elem = 16'($urandom_range(15)) - 16'd8;
                2: elem = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                default: elem = 16'd0;
            endcase
            send_element(elem, k == len - 1);
        end
    endtask

    initial begin
        in_ch.valid         = 1'b0;
        in_ch.element_value = '0;
        in_ch.last_element  = 1'b0;
        out_ch.ready        = 1'b0;
        idle_cycles         = 0;
        sent                = 0;
        src_idle_pct        = 29;
        snk_idle_pct        = 86;
        i_rst_n             = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: single full-scale, zero norm, extremes, overflow
        send_element(16'h7FFF, 1'b1);
        send_element(16'h8000, 1'b1);
        send_element(16'h0000, 1'b0);
        send_element(16'h0000, 1'b1);
        send_element(16'h0001, 1'b0);
        send_element(16'hFFFF, 1'b0);
        send_element(16'h5555, 1'b0);
        send_element(16'hAAAA, 1'b1);
        send_vector(66, 0);
        send_vector(65, 3);

        // Random vectors, three idle phases
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 86 : 0;
            snk_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 29 : 0;
            for (int v = 0; v < 5; v++) begin
                case ($urandom_range(9))
                    0:       send_vector($urandom_range(1, 4), 3);
                    1:       send_vector($urandom_range(1, 6), 2);
                    2:       send_vector($urandom_range(1, 8), 1);
                    default: send_vector($urandom_range(1, 12), 0);
                endcase
            end
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ l2_vector_normalize_unit.f @@
src/l2vn_pkg.sv
src/l2vn_if.sv
src/l2vn_datapath.sv
src/l2vn_ctrl.sv
src/l2_vector_normalize_unit.sv
src/l2vn_checker.sv
sim/l2vn_norm_checker.sv
sim/tb_l2_vector_normalize_unit.sv
